// ===== hw/rtl/kdm_pkg.sv =====
// Package for the key debounce / MIDI note event block.
// Holds the key phase type, the stored key record, MIDI constants, register
// indexes and the default key-to-note map. No dependencies.
package kdm_pkg;

    localparam int NUM_KEYS_DEF = 32;

    localparam int CHAN_W = 5;
    localparam int TIME_W = 64;
    localparam int NOTE_W = 7;
    localparam int LOCK_W = 32;
    localparam int MCH_W  = 4;
    localparam int CFG_W  = 32;
    localparam int CFG_AW = 2;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] STATUS_ON  = 8'h90;
    localparam logic [7:0] STATUS_OFF = 8'h80;

    localparam logic [LOCK_W-1:0] PRESS_LOCK_RST   = LOCK_W'(100 * 1000);
    localparam logic [LOCK_W-1:0] RELEASE_LOCK_RST = LOCK_W'(10 * 1000);
    localparam logic [MCH_W-1:0]  MIDI_CH_RST      = '0;
    localparam logic [NOTE_W-1:0] ON_VEL_RST       = NOTE_W'(64);

    typedef enum logic [CFG_AW-1:0] {
        CFG_PRESS_LOCK   = 2'd0,
        CFG_RELEASE_LOCK = 2'd1,
        CFG_MIDI_CHANNEL = 2'd2,
        CFG_ON_VELOCITY  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HIT     = 4'b0010,
        PH_PRESSED = 4'b0100,
        PH_RELEASE = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [TIME_W-1:0] deadline;
    } key_rec_t;

    localparam key_rec_t REC_RST = '{phase: PH_IDLE, deadline: '0};

    localparam int DEFAULT_MAP_LEN = 29;
    localparam logic [NOTE_W-1:0] DEFAULT_NOTES [DEFAULT_MAP_LEN] = '{
        7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd11, 7'd12,
        7'd0, 7'd67, 7'd64, 7'd60, 7'd69,
        7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd22, 7'd25, 7'd26, 7'd27, 7'd28
    };

    // Note number a key sends until its entry is rewritten.
    function automatic logic [NOTE_W-1:0] default_note(input logic [7:0] idx);
        logic [NOTE_W-1:0] n;
        if (idx < 8'(DEFAULT_MAP_LEN)) begin
            n = DEFAULT_NOTES[idx[4:0]];
        end else begin
            n = idx[NOTE_W-1:0];
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/kdm_rec_ram.sv =====
// Per-key record store: phase and lockout deadline, one entry per key.
// Synchronous memory with registered read and per-entry valid bits.
// Depends on kdm_pkg.
module kdm_rec_ram
    import kdm_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     rd_en,
    input  logic [(NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1)-1:0] rd_addr,
    output key_rec_t rd_rec,
    input  logic     wr_en,
    input  logic [(NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1)-1:0] wr_addr,
    input  key_rec_t wr_rec
);

    key_rec_t            rec_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] vld_reg;
    key_rec_t            rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rec_mem[wr_addr] <= wr_rec;
        end
        if (rd_en) begin
            rd_data_reg <= rec_mem[rd_addr];
        end
    end

    // Entries never written read back as an idle key with a zero deadline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_rec = rd_vld_reg ? rd_data_reg : REC_RST;

endmodule

// ===== hw/rtl/key_debounce_midi_note_events_top.sv =====
// Top level of the multi-key debouncer that emits MIDI note on/off events.
// Depends on kdm_pkg and kdm_rec_ram.
//
// Usage: each input beat on the s_ channel is either a key sample (s_tuser 0)
// or a note-number write for a key channel (s_tuser 1). A sample of an idle
// key held low sends a Note On and starts the press lockout; a sample of a
// pressed key that reads high sends a Note Off and starts the release lockout.
// A lockout ends on the first sample whose time is strictly past its deadline.
// Channels at or above NUM_KEYS are ignored. Note writes never produce output.
//
// Throughput is one beat per clock unless the receiver holds m_tready low. Each
// sample does a read-modify-write of its key record in the record memory: the
// read is issued on the accept edge, the update is computed the next cycle and
// written back, and a back-to-back sample of the same key takes the record just
// written from a bypass register. m_tvalid comes from the output register.
//
// The result sits in an output register. When the receiver holds m_tready low
// the block still accepts one more beat into its compute stage; after that
// s_tready drops until the output register is taken. Reset clears all phases
// to idle, all deadlines to zero, restores the default note map and loads the
// register defaults; it takes effect at once through per-entry valid bits.
// Configuration writes must only happen while the block is idle.
module key_debounce_midi_note_events_top
    import kdm_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input beats.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata from bit 0: channel[4:0], pin_level[5], now_us[69:6],
    // note_value[76:70], zero fill[79:77].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: command (0 key sample, 1 note-number write).
    input  logic                 s_tuser,
    // Result beats.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata from bit 0: key_channel[4:0], status_byte[12:5],
    // note_number[19:13], velocity[26:20], zero fill[31:27].
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: note_on (1 Note On, 0 Note Off).
    output logic                 m_tuser,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int IDX_W = NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1;

    // Configuration registers.
    logic [LOCK_W-1:0] press_lock_reg;
    logic [LOCK_W-1:0] release_lock_reg;
    logic [MCH_W-1:0]  midi_ch_reg;
    logic [NOTE_W-1:0] on_vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_lock_reg   <= PRESS_LOCK_RST;
            release_lock_reg <= RELEASE_LOCK_RST;
            midi_ch_reg      <= MIDI_CH_RST;
            on_vel_reg       <= ON_VEL_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_PRESS_LOCK:   press_lock_reg   <= cfg_wdata[LOCK_W-1:0];
                CFG_RELEASE_LOCK: release_lock_reg <= cfg_wdata[LOCK_W-1:0];
                CFG_MIDI_CHANNEL: midi_ch_reg      <= cfg_wdata[MCH_W-1:0];
                CFG_ON_VELOCITY:  on_vel_reg       <= cfg_wdata[NOTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the input beat.
    logic [CHAN_W-1:0] in_chan;
    logic              in_pin;
    logic [TIME_W-1:0] in_now;
    logic [NOTE_W-1:0] in_note;
    logic [IDX_W-1:0]  in_idx;
    logic              in_range;

    assign in_chan  = s_tdata[CHAN_W-1:0];
    assign in_pin   = s_tdata[CHAN_W];
    assign in_now   = s_tdata[CHAN_W+1 +: TIME_W];
    assign in_note  = s_tdata[CHAN_W+1+TIME_W +: NOTE_W];
    assign in_idx   = IDX_W'(in_chan);
    assign in_range = 32'(in_chan) < NUM_KEYS;

    // Handshake and stage control.
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic s_fire;
    logic s1_fire;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && out_free;

    // Note table: written directly on the accept edge of a note-number write,
    // so any later sample already reads the new value.
    logic [NOTE_W-1:0]   note_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] note_vld_reg;
    logic [NOTE_W-1:0]   note_rd_reg;
    logic                note_vld_rd_reg;
    logic                note_we;
    logic                sample_go;

    assign note_we   = s_fire && s_tuser && in_range;
    assign sample_go = s_fire && !s_tuser && in_range;

    always_ff @(posedge aclk) begin
        if (note_we) begin
            note_mem[in_idx] <= in_note;
        end
        if (sample_go) begin
            note_rd_reg <= note_mem[in_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_vld_reg    <= '0;
            note_vld_rd_reg <= 1'b0;
        end else begin
            if (sample_go) begin
                note_vld_rd_reg <= note_vld_reg[in_idx];
            end
            if (note_we) begin
                note_vld_reg[in_idx] <= 1'b1;
            end
        end
    end

    // Compute stage registers for the sample whose record is being read.
    logic [CHAN_W-1:0] s1_chan_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_pin_reg;
    logic [TIME_W-1:0] s1_now_reg;

    always_ff @(posedge aclk) begin
        if (sample_go) begin
            s1_chan_reg <= in_chan;
            s1_idx_reg  <= in_idx;
            s1_pin_reg  <= in_pin;
            s1_now_reg  <= in_now;
        end
    end

    // Record memory with bypass for a write landing on the same edge as the read.
    key_rec_t         mem_rec;
    key_rec_t         cur_rec;
    key_rec_t         new_rec;
    logic             rec_we;
    logic             emit;
    logic             emit_on;
    logic             byp_valid_reg;
    logic [IDX_W-1:0] byp_idx_reg;
    key_rec_t         byp_rec_reg;

    kdm_rec_ram #(
        .NUM_KEYS(NUM_KEYS)
    ) u_rec_ram (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd_en  (sample_go),
        .rd_addr(in_idx),
        .rd_rec (mem_rec),
        .wr_en  (s1_fire && rec_we),
        .wr_addr(s1_idx_reg),
        .wr_rec (new_rec)
    );

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            byp_idx_reg <= s1_idx_reg;
            byp_rec_reg <= new_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (s_fire) begin
            byp_valid_reg <= s1_fire && rec_we;
        end
    end

    assign cur_rec = (byp_valid_reg && byp_idx_reg == s1_idx_reg) ? byp_rec_reg : mem_rec;

    // Phase update. A sample that ends a lockout does not look at the pin.
    logic [TIME_W-1:0] press_dl;
    logic [TIME_W-1:0] release_dl;
    logic              past_dl;

    assign press_dl   = s1_now_reg + TIME_W'(press_lock_reg);
    assign release_dl = s1_now_reg + TIME_W'(release_lock_reg);
    assign past_dl    = s1_now_reg > cur_rec.deadline;

    always_comb begin
        new_rec = cur_rec;
        rec_we  = 1'b0;
        emit    = 1'b0;
        emit_on = 1'b0;
        case (cur_rec.phase)
            PH_IDLE: begin
                if (!s1_pin_reg) begin
                    new_rec = '{phase: PH_HIT, deadline: press_dl};
                    rec_we  = 1'b1;
                    emit    = 1'b1;
                    emit_on = 1'b1;
                end
            end
            PH_HIT: begin
                if (past_dl) begin
                    new_rec.phase = PH_PRESSED;
                    rec_we        = 1'b1;
                end
            end
            PH_PRESSED: begin
                if (s1_pin_reg) begin
                    new_rec = '{phase: PH_RELEASE, deadline: release_dl};
                    rec_we  = 1'b1;
                    emit    = 1'b1;
                end
            end
            PH_RELEASE: begin
                if (past_dl) begin
                    new_rec.phase = PH_IDLE;
                    rec_we        = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    logic [NOTE_W-1:0] s1_note;
    logic [CHAN_W-1:0] m_chan_reg;
    logic              m_on_reg;
    logic [7:0]        m_status_reg;
    logic [NOTE_W-1:0] m_note_reg;
    logic [NOTE_W-1:0] m_vel_reg;

    assign s1_note = note_vld_rd_reg ? note_rd_reg : default_note(8'(s1_idx_reg));

    always_ff @(posedge aclk) begin
        if (s1_fire && emit) begin
            m_chan_reg   <= s1_chan_reg;
            m_on_reg     <= emit_on;
            m_status_reg <= (emit_on ? STATUS_ON : STATUS_OFF) | {4'b0, midi_ch_reg};
            m_note_reg   <= s1_note;
            m_vel_reg    <= emit_on ? on_vel_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= sample_go;
            end
            if (s1_fire && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_on_reg;
    assign m_tdata  = {5'b0, m_vel_reg, m_note_reg, m_status_reg, m_chan_reg};

    // The input stalls only when a sample waits behind a blocked result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // A result held by the receiver keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Status byte kind and velocity agree with the note_on flag.
    a_msg_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_on_reg && m_status_reg[7:4] == STATUS_ON[7:4])
                      || (!m_on_reg && m_status_reg[7:4] == STATUS_OFF[7:4]
                          && m_vel_reg == '0)))
        else $error("status byte does not match message kind");

endmodule

// ===== tb/sv/key_debounce_midi_note_events_checker.sv =====
// Checker for the key debounce / MIDI note event block: watches the input, result and
// configuration ports, keeps its own per-key debounce state and compares every result beat.
// Depends on kdm_pkg for widths, the phase type, MIDI status codes and the default note map.
module key_debounce_midi_note_events_checker
    import kdm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   fail_count,
    output int                   pending,
    output int                   beats_seen,
    output int                   note_writes,
    output int                   ons_checked,
    output int                   offs_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS        = NUM_KEYS_DEF;
    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic [CHAN_W-1:0] key;
        logic              on;
        logic [7:0]        status;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
    } note_event_t;

    phase_t            key_phase [KEYS];
    logic [TIME_W-1:0] deadline  [KEYS];
    logic [NOTE_W-1:0] note_map  [KEYS];

    logic [LOCK_W-1:0] press_lock;
    logic [LOCK_W-1:0] release_lock;
    logic [MCH_W-1:0]  midi_ch;
    logic [NOTE_W-1:0] on_vel;

    note_event_t due_events [$];

    initial begin
        fail_count   = 0;
        pending      = 0;
        beats_seen   = 0;
        note_writes  = 0;
        ons_checked  = 0;
        offs_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic clear_model();
        for (int i = 0; i < KEYS; i++) begin
            key_phase[i] = PH_IDLE;
            deadline[i]  = '0;
            note_map[i]  = (i < DEFAULT_MAP_LEN) ? DEFAULT_NOTES[i] : NOTE_W'(i);
        end
        press_lock   = PRESS_LOCK_RST;
        release_lock = RELEASE_LOCK_RST;
        midi_ch      = MIDI_CH_RST;
        on_vel       = ON_VEL_RST;
        due_events.delete();
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_PRESS_LOCK:   press_lock   = val[LOCK_W-1:0];
            CFG_RELEASE_LOCK: release_lock = val[LOCK_W-1:0];
            CFG_MIDI_CHANNEL: midi_ch      = val[MCH_W-1:0];
            CFG_ON_VELOCITY:  on_vel       = val[NOTE_W-1:0];
            default: ;
        endcase
    endtask

    // A set s_tuser bit is a note-number write; otherwise the beat samples a key.
    task automatic predict_note_event(input logic note_write, input logic [CHAN_W-1:0] ch,
                                      input logic released, input logic [TIME_W-1:0] now,
                                      input logic [NOTE_W-1:0] nv);
        note_event_t ev;
        logic        fire;
        fire = 1'b0;
        ev   = '0;
        beats_seen++;
        if (int'(ch) < KEYS) begin
            if (note_write) begin
                note_map[ch] = nv;
                note_writes++;
            end else begin
                // A sample that ends a lockout only changes the phase; the pin is
                // looked at again from the next sample of that key.
                case (key_phase[ch])
                    PH_IDLE: begin
                        if (!released) begin
                            key_phase[ch] = PH_HIT;
                            deadline[ch]  = now + TIME_W'(press_lock);
                            fire          = 1'b1;
                            ev.on         = 1'b1;
                        end
                    end
                    PH_HIT: begin
                        if (now > deadline[ch]) key_phase[ch] = PH_PRESSED;
                    end
                    PH_PRESSED: begin
                        if (released) begin
                            key_phase[ch] = PH_RELEASE;
                            deadline[ch]  = now + TIME_W'(release_lock);
                            fire          = 1'b1;
                            ev.on         = 1'b0;
                        end
                    end
                    default: begin
                        if (now > deadline[ch]) key_phase[ch] = PH_IDLE;
                    end
                endcase
            end
        end
        if (fire) begin
            ev.key    = ch;
            ev.status = (ev.on ? STATUS_ON : STATUS_OFF) | {4'h0, midi_ch};
            ev.note   = note_map[ch];
            ev.vel    = ev.on ? on_vel : '0;
            due_events.push_back(ev);
        end
    endtask

    task automatic check_event(input logic [M_TDATA_W-1:0] data, input logic on);
        note_event_t want;
        if (due_events.size() == 0) begin
            report_mismatch($sformatf("result beat 0x%0h with nothing expected", data));
        end else begin
            want = due_events.pop_front();
            if (want.on) ons_checked++;
            else offs_checked++;
            if (data[4:0] !== want.key)
                report_mismatch($sformatf("key_channel expected %0d, got %0d",
                                          want.key, data[4:0]));
            if (on !== want.on)
                report_mismatch($sformatf("note_on expected %0b, got %0b", want.on, on));
            if (data[12:5] !== want.status)
                report_mismatch($sformatf("status_byte expected 0x%0h, got 0x%0h",
                                          want.status, data[12:5]));
            if (data[19:13] !== want.note)
                report_mismatch($sformatf("note_number expected %0d, got %0d",
                                          want.note, data[19:13]));
            if (data[26:20] !== want.vel)
                report_mismatch($sformatf("velocity expected %0d, got %0d",
                                          want.vel, data[26:20]));
            if (data[31:27] !== 5'b0)
                report_mismatch($sformatf("fill bits of m_tdata are 0x%0h", data[31:27]));
        end
    endtask

    // Results are compared before the beat accepted at the same edge is predicted,
    // so a result can never be matched against its own input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            if (m_tvalid && m_tready) check_event(m_tdata, m_tuser);
            if (cfg_we) write_register(cfg_idx_t'(cfg_addr), cfg_wdata);
            if (s_tvalid && s_tready)
                predict_note_event(s_tuser, s_tdata[4:0], s_tdata[5], s_tdata[69:6],
                                   s_tdata[76:70]);
        end
        pending = due_events.size();
    end

endmodule

// ===== tb/sv/key_debounce_midi_note_events_top_tb.sv =====
// Top of the testbench for key_debounce_midi_note_events_top: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on kdm_pkg, the block itself and
// key_debounce_midi_note_events_checker, which does all prediction and comparison.
module key_debounce_midi_note_events_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kdm_pkg::*;

    // s_tuser codes.
    localparam logic CMD_SAMPLE     = 1'b0;
    localparam logic CMD_NOTE_WRITE = 1'b1;

    // Pin levels; the keys are active low.
    localparam logic PIN_DOWN = 1'b0;
    localparam logic PIN_UP   = 1'b1;

    localparam int          RESET_CYCLES = 11;
    localparam int          PHASE_BEATS  = 245;
    localparam int          LONG_HOLD    = 300;
    // The block registers each result through its compute stage and output register;
    // these waits are comfortably longer than that.
    localparam int          SETTLE       = 8;
    localparam int          END_SETTLE   = 16;
    localparam int unsigned LIMIT_CYCLES = 500_000;

    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int pending;
    int beats_seen;
    int note_writes;
    int ons_checked;
    int offs_checked;

    int unsigned       cycle_count = 0;
    int                beat_count  = 0;
    // The stimulus raises hold_reqs; the receiver process answers each request
    // with one long stretch of m_tready low and counts it in hold_done.
    int                hold_reqs   = 0;
    int                hold_done   = 0;
    int                stall_left  = 0;
    logic [TIME_W-1:0] t_now       = '0;
    // What each key is meant to be doing in the random part; samples add bounce on top.
    logic              key_down [NUM_KEYS_DEF];

    key_debounce_midi_note_events_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    key_debounce_midi_note_events_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .beats_seen   (beats_seen),
        .note_writes  (note_writes),
        .ons_checked  (ons_checked),
        .offs_checked (offs_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge aclk);
        $display("Timeout after %0d cycles with %0d results still expected.",
                 cycle_count, pending);
        $display("Regression FAIL");
        $finish;
    end

    // Length of one pause: mostly a few cycles, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sender gap before a beat. Every fourth stretch of 50 beats runs with no
    // gaps at all, so the block also sees long back-to-back bursts.
    function automatic int sender_gap();
        if ((beat_count / 50) % 4 == 3) return 0;
        if ($urandom_range(0, 99) < 55) return 0;
        return pause_len();
    endfunction

    // Receiver. Random stalls, except in one of every three windows of cycle_count,
    // where no new random stall starts. A hold request keeps m_tready low for a
    // stretch set by LONG_HOLD while the sender keeps offering beats, so the
    // compute stage and the output register fill up and s_tready has to drop.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_done != hold_reqs) begin
                hold_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if ((cycle_count / 300) % 3 != 1 && $urandom_range(0, 99) < 25) begin
                stall_left = pause_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one beat and returns at the edge where it is accepted. s_tvalid
    // stays high into the next call unless that call starts with a gap.
    task automatic send_beat(input logic cmd, input logic [CHAN_W-1:0] ch, input logic pin,
                             input logic [TIME_W-1:0] now, input logic [NOTE_W-1:0] nv);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        // Fields from bit 0: channel, pin_level, now_us, note_value, zero fill.
        s_tdata  <= {3'b000, nv, now, pin, ch};
        do @(posedge aclk); while (!s_tready);
        beat_count++;
    endtask

    task automatic sample_key(input logic [CHAN_W-1:0] ch, input logic pin,
                              input logic [TIME_W-1:0] now);
        send_beat(CMD_SAMPLE, ch, pin, now, NOTE_W'($urandom_range(0, 127)));
    endtask

    task automatic write_note(input logic [CHAN_W-1:0] ch, input logic [NOTE_W-1:0] nv);
        send_beat(CMD_NOTE_WRITE, ch, 1'($urandom_range(0, 1)), {$urandom, $urandom}, nv);
    endtask

    // Stop sending and wait until every expected result is in, then let the
    // pipeline empty of beats that make no result.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Only called while the block is idle: straight after a drain.
    task automatic set_regs(input logic [LOCK_W-1:0] press, input logic [LOCK_W-1:0] rel,
                            input logic [MCH_W-1:0] mch, input logic [NOTE_W-1:0] vel);
        put_reg(CFG_PRESS_LOCK, CFG_W'(press));
        put_reg(CFG_RELEASE_LOCK, CFG_W'(rel));
        put_reg(CFG_MIDI_CHANNEL, CFG_W'(mch));
        put_reg(CFG_ON_VELOCITY, CFG_W'(vel));
        cfg_we <= 1'b0;
    endtask

    // Random traffic. Most beats hit four hot keys so that each goes through
    // press, lockout, release and release lockout many times, with time moving
    // forward in steps comparable to the lockouts. The rest are stray keys,
    // note writes, bounce on the pin, times that jump back and fully random times.
    task automatic run_phase(input int n, input logic [TIME_W-1:0] base,
                             input int unsigned step_max, input bit with_hold);
        logic [CHAN_W-1:0] hot [4];
        logic [CHAN_W-1:0] ch;
        logic [TIME_W-1:0] now;
        logic              cmd;
        logic              pin;
        int                r;
        t_now = base;
        for (int i = 0; i < 4; i++) hot[i] = CHAN_W'($urandom_range(0, 31));
        for (int k = 0; k < n; k++) begin
            if (with_hold && k == n / 3) hold_reqs++;
            ch  = ($urandom_range(0, 99) < 70) ? hot[$urandom_range(0, 3)]
                                               : CHAN_W'($urandom_range(0, 31));
            cmd = ($urandom_range(0, 99) < 5) ? CMD_NOTE_WRITE : CMD_SAMPLE;
            if ($urandom_range(0, 99) < 12) key_down[ch] = ~key_down[ch];
            pin = key_down[ch] ? PIN_DOWN : PIN_UP;
            if ($urandom_range(0, 99) < 8) pin = ~pin;
            r = $urandom_range(0, 99);
            if (r < 2) begin
                now = {$urandom, $urandom};
            end else if (r < 4) begin
                now = t_now - TIME_W'($urandom_range(0, step_max));
            end else begin
                t_now = t_now + TIME_W'($urandom_range(0, step_max));
                now   = t_now;
            end
            send_beat(cmd, ch, pin, now, NOTE_W'($urandom_range(0, 127)));
        end
    endtask

    initial begin
        logic [LOCK_W-1:0] rnd_press;
        logic [LOCK_W-1:0] rnd_release;

        for (int i = 0; i < NUM_KEYS_DEF; i++) key_down[i] = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset register values (press lockout 100000, release
        // 10000). Key 31 walks the whole cycle with its note rewritten mid-press,
        // hits the deadline exactly (not yet past), and shows that the sample
        // ending a lockout ignores the pin.
        write_note(5'd31, 7'd127);
        write_note(5'd21, 7'd85);
        sample_key(5'd31, PIN_UP, 64'd0);
        sample_key(5'd31, PIN_DOWN, 64'd5);
        write_note(5'd31, 7'd42);
        sample_key(5'd31, PIN_DOWN, 64'd100005);
        sample_key(5'd31, PIN_UP, 64'd100006);
        sample_key(5'd31, PIN_DOWN, 64'd100007);
        sample_key(5'd31, PIN_UP, 64'd100008);
        sample_key(5'd31, PIN_DOWN, 64'd110008);
        sample_key(5'd31, PIN_DOWN, 64'd110009);
        sample_key(5'd31, PIN_DOWN, 64'd110010);
        // Key 0 pressed and released at the very top of the time range: both
        // deadlines wrap past zero and end on small times.
        sample_key(5'd0, PIN_DOWN, TIME_TOP);
        sample_key(5'd0, PIN_UP, 64'd99999);
        sample_key(5'd0, PIN_UP, 64'd100000);
        sample_key(5'd0, PIN_UP, TIME_TOP);
        sample_key(5'd0, PIN_DOWN, 64'd10000);
        sample_key(5'd0, PIN_UP, 64'd10001);
        write_note(5'd0, 7'd0);
        sample_key(5'd21, PIN_DOWN, 64'h8000_0000_0000_0000);
        sample_key(5'd13, PIN_DOWN, 64'd1);
        sample_key(5'd17, PIN_DOWN, 64'd2);

        // Reset register values, with one long receiver hold.
        run_phase(PHASE_BEATS, 64'd200000, 32'd20000, 1'b1);

        // Zero lockouts: a lockout ends on the first sample with a later time,
        // and time often stands still. Top MIDI channel and velocity.
        drain();
        set_regs('0, '0, 4'd15, 7'd127);
        run_phase(PHASE_BEATS, {$urandom, $urandom}, 32'd2, 1'b0);

        // Short lockouts with time running through the wrap from all ones to zero.
        drain();
        set_regs(32'd40, 32'd7, 4'd6, 7'd0);
        run_phase(PHASE_BEATS, 64'hFFFF_FFFF_FFFF_FE00, 32'd6, 1'b0);

        // Largest lockouts with huge time steps near the top, so deadlines wrap.
        drain();
        set_regs('1, '1, 4'd9, 7'd1);
        run_phase(PHASE_BEATS, 64'hFFFF_FFF0_0000_0000, 32'hFFFF_FFFF, 1'b0);

        // Random settings, with a second long hold.
        drain();
        rnd_press   = LOCK_W'($urandom_range(1, 5000));
        rnd_release = LOCK_W'($urandom_range(1, 2000));
        set_regs(rnd_press, rnd_release, MCH_W'($urandom_range(0, 15)),
                 NOTE_W'($urandom_range(0, 127)));
        run_phase(PHASE_BEATS, {$urandom, $urandom}, (rnd_press + rnd_release) / 6 + 1, 1'b1);

        drain();
        repeat (END_SETTLE) @(posedge aclk);

        $display("Covered %0d input beats, %0d of them note writes, over five register",
                 beats_seen, note_writes);
        $display("settings; checked %0d note-on and %0d note-off events in %0d cycles.",
                 ons_checked, offs_checked, cycle_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches found.", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/kdm_pkg.sv
hw/rtl/kdm_rec_ram.sv
hw/rtl/key_debounce_midi_note_events_top.sv
tb/sv/key_debounce_midi_note_events_checker.sv
tb/sv/key_debounce_midi_note_events_top_tb.sv
